FILE: rtl/core/mh_pkg.sv
`default_nettype none

package mh_pkg;

	// Fraction bits added below each axis reading inside the rotation datapath
	localparam int unsigned GUARD_BITS = 8;

	// Rotation datapath width: sign, 16-bit reading, guard bits, and headroom for
	// the negated most negative reading times the CORDIC gain of about 1.65
	localparam int unsigned CW = 16 + GUARD_BITS + 3;

	// Entries in the arctangent table, the most rotation steps supported
	localparam int unsigned ATAN_LEN = 24;

	// Degrees in a full turn
	localparam logic [8:0] DEG_PER_TURN = 9'd360;

	// atan(2^-i) as a 32-bit fraction of a full turn
	localparam logic [31:0] ATAN_TURN32 [ATAN_LEN] = '{
		32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
		32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
		32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
		32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
		32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
		32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
	};

	// Axis readings carried alongside the rotation, plus the zero-vector flag
	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic               zero;
	} axes_t;

	// Step angle rescaled to a turn_bits-wide fraction, rounded half up
	function automatic logic [31:0] step_angle(input int unsigned idx,
		input int unsigned turn_bits);
		logic [63:0] t;
		t = {32'd0, ATAN_TURN32[idx]} << turn_bits;
		t = t + 64'h0000_0000_8000_0000;
		return t[63:32];
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/magnetometer_heading_top.sv
`default_nettype none

// Magnetometer heading pipeline. Each transaction carries one six-byte sample
// in device order (X pair, Z pair, Y pair, high byte first); the result gives
// the three signed axis readings and a compass heading in whole degrees,
// floor(atan2(y, x)) wrapped into 0..359, with 0 for a zero X/Y vector. The
// angle comes from an unrolled CORDIC vectoring unit, one rotation step per
// register stage, kept as a TURN_BITS-wide fraction of a turn and then scaled
// by 360. One sample is accepted every cycle while in_ready is high; the pipeline
// has an entry stage, one stage per rotation step and a scaling stage. Every
// stage holds its transaction while the next is full, so stalls on the output
// side fill empty stages first before input ready drops.
module magnetometer_heading_top
	import mh_pkg::*;
#(
	parameter int unsigned CORDIC_STEPS = 20,
	parameter int unsigned TURN_BITS    = 24
) (
	input  wire logic               clk,
	input  wire logic               arst_n,

	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         x_high,
	input  wire logic [7:0]         x_low,
	input  wire logic [7:0]         z_high,
	input  wire logic [7:0]         z_low,
	input  wire logic [7:0]         y_high,
	input  wire logic [7:0]         y_low,

	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [15:0]      x_field,
	output logic signed [15:0]      y_field,
	output logic signed [15:0]      z_field,
	output logic [8:0]              heading_deg
);

	localparam int unsigned PW = TURN_BITS + 9;

	// ---------------------------------------------------------------
	// Stage 1: assemble readings, pre-rotate into the right half plane
	// ---------------------------------------------------------------
	logic                          v_s1;
	logic                          en_s1;
	axes_t                         ax_s1;
	logic signed [CW-1:0]          cx_s1;
	logic signed [CW-1:0]          cy_s1;
	logic [TURN_BITS-1:0]          ang_s1;

	logic signed [15:0]            xr_c;
	logic signed [15:0]            yr_c;
	logic signed [15:0]            zr_c;
	logic signed [CW-1:0]          xe_c;
	logic signed [CW-1:0]          ye_c;

	// Rotation stages
	logic                          v_s2   [CORDIC_STEPS];
	logic                          en_s2  [CORDIC_STEPS];
	axes_t                         ax_s2  [CORDIC_STEPS];
	logic signed [CW-1:0]          cx_s2  [CORDIC_STEPS];
	logic signed [CW-1:0]          cy_s2  [CORDIC_STEPS];
	logic [TURN_BITS-1:0]          ang_s2 [CORDIC_STEPS];

	// Output stage: turn fraction times 360
	logic                          v_s3;
	logic                          en_s3;
	axes_t                         ax_s3;
	logic [PW-1:0]                 prod_s3;
	logic [TURN_BITS-1:0]          ang_last;

	assign xr_c = signed'({x_high, x_low});
	assign yr_c = signed'({y_high, y_low});
	assign zr_c = signed'({z_high, z_low});
	assign xe_c = signed'({{(CW-16-GUARD_BITS){xr_c[15]}}, xr_c, {GUARD_BITS{1'b0}}});
	assign ye_c = signed'({{(CW-16-GUARD_BITS){yr_c[15]}}, yr_c, {GUARD_BITS{1'b0}}});

	// Stage enables: a stage loads when empty or when its content moves on
	assign en_s3    = !v_s3 || out_ready;
	assign en_s1    = !v_s1 || en_s2[0];
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			ax_s1.x    <= xr_c;
			ax_s1.y    <= yr_c;
			ax_s1.z    <= zr_c;
			ax_s1.zero <= (xr_c == 16'sd0) && (yr_c == 16'sd0);
			if (xr_c[15]) begin
				cx_s1  <= -xe_c;
				cy_s1  <= -ye_c;
				ang_s1 <= {1'b1, {(TURN_BITS-1){1'b0}}};
			end else begin
				cx_s1  <= xe_c;
				cy_s1  <= ye_c;
				ang_s1 <= '0;
			end
		end
	end

	// ---------------------------------------------------------------
	// CORDIC vectoring: one micro-rotation per stage
	// ---------------------------------------------------------------
	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
		localparam logic [31:0] STEP_W = step_angle(k, TURN_BITS);
		localparam logic [TURN_BITS-1:0] STEP_A = STEP_W[TURN_BITS-1:0];

		logic                       v_in;
		axes_t                      ax_in;
		logic signed [CW-1:0]       cx_in;
		logic signed [CW-1:0]       cy_in;
		logic [TURN_BITS-1:0]       ang_in;
		logic signed [CW-1:0]       dx_c;
		logic signed [CW-1:0]       dy_c;

		if (k == 0) begin : g_first
			assign v_in   = v_s1;
			assign ax_in  = ax_s1;
			assign cx_in  = cx_s1;
			assign cy_in  = cy_s1;
			assign ang_in = ang_s1;
		end else begin : g_next
			assign v_in   = v_s2[k-1];
			assign ax_in  = ax_s2[k-1];
			assign cx_in  = cx_s2[k-1];
			assign cy_in  = cy_s2[k-1];
			assign ang_in = ang_s2[k-1];
		end

		if (k == CORDIC_STEPS - 1) begin : g_en_last
			assign en_s2[k] = !v_s2[k] || en_s3;
		end else begin : g_en_mid
			assign en_s2[k] = !v_s2[k] || en_s2[k+1];
		end

		// arithmetic shifts round toward minus infinity
		assign dx_c = cy_in >>> k;
		assign dy_c = cx_in >>> k;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s2[k] <= 1'b0;
			end else if (en_s2[k]) begin
				v_s2[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en_s2[k] && v_in) begin
				ax_s2[k] <= ax_in;
				if (cy_in > 0) begin
					cx_s2[k]  <= cx_in + dx_c;
					cy_s2[k]  <= cy_in - dy_c;
					ang_s2[k] <= ang_in + STEP_A;
				end else begin
					cx_s2[k]  <= cx_in - dx_c;
					cy_s2[k]  <= cy_in + dy_c;
					ang_s2[k] <= ang_in - STEP_A;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Output stage: scale to degrees, zero vector forces heading 0
	// ---------------------------------------------------------------
	assign ang_last = ang_s2[CORDIC_STEPS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en_s3) begin
			v_s3 <= v_s2[CORDIC_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2[CORDIC_STEPS-1]) begin
			ax_s3 <= ax_s2[CORDIC_STEPS-1];
			if (ax_s2[CORDIC_STEPS-1].zero) begin
				prod_s3 <= '0;
			end else begin
				prod_s3 <= {9'd0, ang_last} * {{TURN_BITS{1'b0}}, DEG_PER_TURN};
			end
		end
	end

	assign out_valid   = v_s3;
	assign x_field     = ax_s3.x;
	assign y_field     = ax_s3.y;
	assign z_field     = ax_s3.z;
	assign heading_deg = prod_s3[PW-1:TURN_BITS];

endmodule

`default_nettype wire

FILE: rtl/core/mh_check.sv
`default_nettype none

// Port-level checks for the heading pipeline
module mh_check (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic [7:0]         x_high,
	input wire logic [7:0]         x_low,
	input wire logic [7:0]         z_high,
	input wire logic [7:0]         z_low,
	input wire logic [7:0]         y_high,
	input wire logic [7:0]         y_low,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic signed [15:0] x_field,
	input wire logic signed [15:0] y_field,
	input wire logic signed [15:0] z_field,
	input wire logic [8:0]         heading_deg
);

	// a stalled sample transaction holds its payload
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(x_high) && $stable(x_low)
			&& $stable(z_high) && $stable(z_low) && $stable(y_high) && $stable(y_low))
		else $error("stalled sample changed or dropped");

	// a stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(x_field) && $stable(y_field)
			&& $stable(z_field) && $stable(heading_deg))
		else $error("stalled result changed or dropped");

	// heading stays within one turn
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> heading_deg < 9'd360)
		else $error("heading out of range");

	// zero X/Y vector reports heading 0
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && x_field == 16'sd0 && y_field == 16'sd0 |-> heading_deg == 9'd0)
		else $error("zero vector heading not 0");

	// with the output stage empty the pipeline must take input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output stage");

endmodule

bind magnetometer_heading_top mh_check u_mh_check (.*);

`default_nettype wire

FILE: dv/heading_monitor.sv
// Watches both channels of the heading pipeline, predicts each result from the
// sample that went in and compares it with what comes out, in order.
module heading_monitor
	import mh_pkg::*;
#(
	parameter int unsigned CORDIC_STEPS = 20,
	parameter int unsigned TURN_BITS    = 24
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire logic [7:0]         x_high,
	input  wire logic [7:0]         x_low,
	input  wire logic [7:0]         z_high,
	input  wire logic [7:0]         z_low,
	input  wire logic [7:0]         y_high,
	input  wire logic [7:0]         y_low,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	input  wire logic signed [15:0] x_field,
	input  wire logic signed [15:0] y_field,
	input  wire logic signed [15:0] z_field,
	input  wire logic [8:0]         heading_deg,
	output int                      mismatches,
	output int                      awaiting
);

	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic [8:0]         deg;
	} reading_t;

	reading_t due_readings[$];
	reading_t want;
	int       miss_count;

	// Vectoring CORDIC on the X/Y pair; angle kept as a TURN_BITS fraction of a turn
	function automatic logic [8:0] compass_heading(input logic signed [15:0] xr,
		input logic signed [15:0] yr);
		longint      xa, ya, dx, dy;
		logic [63:0] turn, rot, mask;
		int unsigned steps;
		if (xr == 0 && yr == 0)
			return 9'd0;
		mask = (64'd1 << TURN_BITS) - 64'd1;
		turn = 64'd0;
		xa = longint'(xr) * (64'sd1 <<< GUARD_BITS);
		ya = longint'(yr) * (64'sd1 <<< GUARD_BITS);
		// left half plane: flip the vector, start from half a turn
		if (xa < 0) begin
			xa = -xa;
			ya = -ya;
			turn = 64'd1 << (TURN_BITS - 1);
		end
		steps = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
		for (int unsigned i = 0; i < steps; i++) begin
			dx = ya >>> i;
			dy = xa >>> i;
			// table entry rescaled to the turn width, rounded half up
			rot = (({32'd0, ATAN_TURN32[i]} << TURN_BITS) + 64'h8000_0000) >> 32;
			if (ya > 0) begin
				xa = xa + dx;
				ya = ya - dy;
				turn = (turn + rot) & mask;
			end else begin
				xa = xa - dx;
				ya = ya + dy;
				turn = (turn - rot) & mask;
			end
		end
		return 9'((turn * 64'd360) >> TURN_BITS);
	endfunction

	task automatic field_check(input string label, input int exp_v, input int got_v);
		if (exp_v != got_v) begin
			miss_count++;
			if (miss_count <= 10)
				$display("mismatch %0d on %s: expected %0d, got %0d",
					miss_count, label, exp_v, got_v);
		end
	endtask

	// Queue a prediction per input transaction, check each output transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			due_readings.delete();
			miss_count = 0;
			mismatches <= 0;
			awaiting <= 0;
		end else begin
			if (in_valid && in_ready) begin
				want.x = {x_high, x_low};
				want.y = {y_high, y_low};
				want.z = {z_high, z_low};
				want.deg = compass_heading(want.x, want.y);
				due_readings.push_back(want);
			end
			if (out_valid && out_ready) begin
				if (due_readings.size() == 0) begin
					miss_count++;
					if (miss_count <= 10)
						$display("mismatch %0d: result with none pending (x %0d y %0d z %0d deg %0d)",
							miss_count, x_field, y_field, z_field, heading_deg);
				end else begin
					want = due_readings.pop_front();
					field_check("x_field", want.x, x_field);
					field_check("y_field", want.y, y_field);
					field_check("z_field", want.z, z_field);
					field_check("heading_deg", want.deg, heading_deg);
				end
			end
			mismatches <= miss_count;
			awaiting <= due_readings.size();
		end
	end

endmodule

FILE: dv/tb.sv
// Drives magnetometer samples into the heading pipeline with random gaps and
// output stalls; the monitor does the checking.
module tb;

	localparam int unsigned CORDIC_STEPS = 20;
	localparam int unsigned TURN_BITS    = 24;
	localparam int unsigned LATENCY      = CORDIC_STEPS + 2;
	localparam int          QUIET_LIMIT  = 4000;
	localparam int          RANDOM_ITEMS = 1000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [7:0]         x_high, x_low, z_high, z_low, y_high, y_low;
	logic               out_valid;
	logic               out_ready;
	logic signed [15:0] x_field, y_field, z_field;
	logic [8:0]         heading_deg;
	int                 mismatches;
	int                 awaiting;
	logic               calm;
	int                 quiet;

	magnetometer_heading_top #(
		.CORDIC_STEPS(CORDIC_STEPS),
		.TURN_BITS   (TURN_BITS)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.x_high     (x_high),
		.x_low      (x_low),
		.z_high     (z_high),
		.z_low      (z_low),
		.y_high     (y_high),
		.y_low      (y_low),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.x_field    (x_field),
		.y_field    (y_field),
		.z_field    (z_field),
		.heading_deg(heading_deg)
	);

	heading_monitor #(
		.CORDIC_STEPS(CORDIC_STEPS),
		.TURN_BITS   (TURN_BITS)
	) monitor (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.x_high     (x_high),
		.x_low      (x_low),
		.z_high     (z_high),
		.z_low      (z_low),
		.y_high     (y_high),
		.y_low      (y_low),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.x_field    (x_field),
		.y_field    (y_field),
		.z_field    (z_field),
		.heading_deg(heading_deg),
		.mismatches (mismatches),
		.awaiting   (awaiting)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// One sample transaction: optional gap, then hold valid until taken
	task automatic send_sample(input logic [15:0] xw, input logic [15:0] zw,
		input logic [15:0] yw);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 6);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		x_high <= xw[15:8];
		x_low <= xw[7:0];
		z_high <= zw[15:8];
		z_low <= zw[7:0];
		y_high <= yw[15:8];
		y_low <= yw[7:0];
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Hold off the sender until the pipeline has drained
	task automatic drain_pipe();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaiting != 0) @(posedge clk);
	endtask

	// Result side: random stall before each result
	initial begin
		int stall;
		out_ready <= 1'b0;
		forever begin
			stall = calm ? 0 : $urandom_range(0, 6);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else if (quiet >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else
			quiet <= quiet + 1;
	end

	initial begin
		logic [15:0] xw, yw, zw;
		int          pick;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		x_high <= 8'd0;
		x_low <= 8'd0;
		z_high <= 8'd0;
		z_low <= 8'd0;
		y_high <= 8'd0;
		y_low <= 8'd0;
		calm <= 1'b0;
		quiet <= 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero vector, with Z at zero, -1 and its extremes
		send_sample(16'h0000, 16'h0000, 16'h0000);
		send_sample(16'h0000, 16'h7FFF, 16'h0000);
		send_sample(16'h0000, 16'h8000, 16'h0000);
		send_sample(16'h0000, 16'hFFFF, 16'h0000);
		// axes and diagonals at full scale, most negative reading included
		send_sample(16'h7FFF, 16'h00FF, 16'h0000);
		send_sample(16'h8000, 16'hFF00, 16'h0000);
		send_sample(16'h0000, 16'h0001, 16'h7FFF);
		send_sample(16'h0000, 16'h5555, 16'h8000);
		send_sample(16'h8000, 16'hAAAA, 16'h8000);
		send_sample(16'h7FFF, 16'h1234, 16'h7FFF);
		send_sample(16'h8000, 16'h0000, 16'h7FFF);
		send_sample(16'h7FFF, 16'h0000, 16'h8000);
		send_sample(16'hFFFF, 16'h0000, 16'hFFFF);
		// unit steps around the circle
		send_sample(16'h0001, 16'h0000, 16'h0000);
		send_sample(16'h0000, 16'h0000, 16'h0001);
		send_sample(16'hFFFF, 16'h0000, 16'h0000);
		send_sample(16'h0000, 16'h0000, 16'hFFFF);
		send_sample(16'h0001, 16'h0000, 16'h0001);
		// tiny negative angle wraps to just under a full turn, then both sides of half a turn
		send_sample(16'h7FFF, 16'h0000, 16'hFFFF);
		send_sample(16'h0064, 16'h0000, 16'hFFFF);
		send_sample(16'h8000, 16'h0000, 16'hFFFF);
		send_sample(16'h8000, 16'h0000, 16'h0001);
		drain_pipe();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 50 == 0)
				calm <= ($urandom_range(0, 3) == 0);
			if (n == RANDOM_ITEMS / 2)
				drain_pipe();
			pick = $urandom_range(0, 9);
			xw = 16'($urandom);
			yw = 16'($urandom);
			zw = 16'($urandom);
			if (pick == 7) begin
				// small magnitudes near the origin
				xw = 16'($urandom_range(0, 8)) - 16'd4;
				yw = 16'($urandom_range(0, 8)) - 16'd4;
			end else if (pick == 8) begin
				// close to an axis
				if ($urandom_range(0, 1) == 1)
					yw = 16'($urandom_range(0, 4)) - 16'd2;
				else
					xw = 16'($urandom_range(0, 4)) - 16'd2;
			end else if (pick == 9) begin
				// extremes mixed with random values
				xw = ($urandom_range(0, 1) == 1) ? 16'h8000 : 16'h7FFF;
				if ($urandom_range(0, 1) == 1)
					yw = ($urandom_range(0, 1) == 1) ? 16'h8000 : 16'h7FFF;
			end
			send_sample(xw, zw, yw);
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (awaiting != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		if (mismatches == 0 && awaiting == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
